// ----- rtl/kpt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the keyframe playback timer.
// No dependencies; every other file in rtl/ imports this package.
package kpt_pkg;

  localparam int TIME_BITS     = 20;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_KEYFRAMES = 1024;

  localparam int KF_BITS      = $clog2(MAX_KEYFRAMES);
  localparam int COUNT_BITS   = KF_BITS + 1;
  localparam int TIMER_BITS   = TIME_BITS + 1;
  localparam int DEN_BITS     = TIMER_BITS + 1;
  localparam int ACC_BITS     = DEN_BITS + 1;
  localparam int BLEND_BITS   = FRAC_BITS + 1;
  localparam int STEP_BITS    = $clog2(TIMER_BITS + 1);
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = TIME_BITS;

  localparam logic [TIME_BITS-1:0]    PERIOD_RESET = TIME_BITS'(16667);
  localparam logic [COUNT_BITS-1:0]   COUNT_RESET  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX    = COUNT_BITS'(MAX_KEYFRAMES);
  localparam logic [BLEND_BITS-1:0]   BLEND_ONE    = BLEND_BITS'(1) << FRAC_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP   = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PLAY  = 2'd1,
    OP_PAUSE = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  // result of the shared compare/subtract unit
  typedef struct packed {
    logic                ge;
    logic [ACC_BITS-1:0] diff;
  } sub_res_t;

  function automatic logic [TIME_BITS-1:0] eff_period(input logic [TIME_BITS-1:0] p);
    eff_period = (p == '0) ? TIME_BITS'(1) : p;
  endfunction

  function automatic logic [COUNT_BITS-1:0] eff_count(input logic [COUNT_BITS-1:0] c);
    if (c == '0) begin
      eff_count = COUNT_BITS'(1);
    end else if (c > COUNT_MAX) begin
      eff_count = COUNT_MAX;
    end else begin
      eff_count = c;
    end
  endfunction

endpackage

// ----- rtl/keyframe_playback_timer_top.sv -----
`timescale 1ns / 1ps
// Keyframe playback timer, top level. Depends on kpt_pkg, kpt_cmpsub, kpt_modstep.
// Flow: play/pause/stop and ticks while not playing go from accept straight to S_WB; a playing
//   tick runs S_PREP, S_DIVK and S_SETB (frame step only), S_DIVB, then S_WB.
// Throughput: one transaction at a time, next accept in the cycle the result is presented,
//   after any wait in S_WB on a pending earlier result; one quotient bit per cycle.
// Reset (rst_ni low, async): stopped, frame 0, timer/blend 0, period 16667, count 1, no loop.
module keyframe_playback_timer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_wr_en_i,
  input  logic [kpt_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [kpt_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  // operation transactions
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [kpt_pkg::TIME_BITS-1:0]     elapsed_time_i,
  // result transactions
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kpt_pkg::KF_BITS-1:0]       current_keyframe_o,
  output logic [kpt_pkg::KF_BITS-1:0]       next_keyframe_o,
  output logic [kpt_pkg::BLEND_BITS-1:0]    blend_factor_o,
  output logic [1:0]                        play_mode_o,
  output logic                              animation_ended_o
);
  import kpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a transaction
    S_PREP,   // tick: decide whether frames are stepped
    S_DIVK,   // k = (timer-1)/period, one quotient bit per cycle
    S_SETB,   // new timer and blend divisor from the remainder
    S_DIVB,   // blend = timer*2^16/((k+1)*period), one bit per cycle
    S_WB      // commit state, present result
  } state_e;

  state_e state_q;

  // configuration registers
  logic [TIME_BITS-1:0]  period_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  loop_q;

  // kept state; doubles as the output register
  logic [TIMER_BITS-1:0] ktimer_q;
  logic [KF_BITS-1:0]    kcur_q;
  logic [KF_BITS-1:0]    knext_q;
  logic [BLEND_BITS-1:0] kblend_q;
  mode_e                 kmode_q;
  logic                  kended_q;
  logic                  out_valid_q;

  // per-transaction working registers
  op_e                   op_q;
  logic [TIMER_BITS-1:0] timer_q;   // timer plus elapsed
  logic [TIMER_BITS-1:0] divn_q;    // dividend shift register for k
  logic [TIMER_BITS-1:0] k_q;       // frames stepped
  logic [DEN_BITS-1:0]   rem_q;     // partial remainder
  logic [DEN_BITS-1:0]   den_q;     // divisor of the running division
  logic [TIMER_BITS-1:0] nt_q;      // timer after stepping
  logic [BLEND_BITS-1:0] bq_q;      // blend quotient
  logic [KF_BITS-1:0]    kmod_q;    // k mod count
  logic [KF_BITS-1:0]    first_q;   // (next+1) mod count
  logic [COUNT_BITS-1:0] nsh_q;     // next+1, shifted out MSB first
  logic [STEP_BITS-1:0]  cnt_q;
  logic                  stepped_q;

  logic [TIME_BITS-1:0]  pe;
  logic [COUNT_BITS-1:0] ce;

  assign pe = eff_period(period_q);
  assign ce = eff_count(count_q);

  // shared compare/subtract unit
  logic [ACC_BITS-1:0] sub_a;
  sub_res_t            sub_res;
  logic [DEN_BITS-1:0] rem_d;

  always_comb begin
    case (state_q)
      S_DIVK:  sub_a = ACC_BITS'({rem_q[TIME_BITS-1:0], divn_q[TIMER_BITS-1]});
      S_DIVB:  sub_a = (cnt_q == '0) ? ACC_BITS'(rem_q) : {rem_q, 1'b0};
      default: sub_a = '0;
    endcase
  end

  kpt_cmpsub u_cmpsub (
    .a_i   (sub_a),
    .b_i   (den_q),
    .res_o (sub_res)
  );

  assign rem_d = sub_res.ge ? sub_res.diff[DEN_BITS-1:0] : sub_a[DEN_BITS-1:0];

  // residue step: k bits during S_DIVK, bits of next+1 during S_DIVB
  logic [KF_BITS-1:0] mod_in;
  logic               mod_bit;
  logic [KF_BITS-1:0] mod_res;

  assign mod_in  = (state_q == S_DIVK) ? kmod_q : first_q;
  assign mod_bit = (state_q == S_DIVK) ? sub_res.ge : nsh_q[COUNT_BITS-1];

  kpt_modstep u_modstep (
    .res_i   (mod_in),
    .bit_i   (mod_bit),
    .count_i (ce),
    .res_o   (mod_res)
  );

  // setup values for the blend division after a frame step:
  // new timer = rem+1, (k+1)*period = timer + period - new timer
  logic [TIMER_BITS-1:0] nt_d;
  logic [DEN_BITS-1:0]   den_d;

  assign nt_d  = TIMER_BITS'(rem_q[TIME_BITS-1:0]) + TIMER_BITS'(1);
  assign den_d = DEN_BITS'(timer_q) + DEN_BITS'(pe)
               - DEN_BITS'(rem_q[TIME_BITS-1:0]) - DEN_BITS'(1);

  // keyframe update at commit
  logic [COUNT_BITS-1:0] step_sum;
  logic [COUNT_BITS-1:0] step_m1;
  logic [COUNT_BITS-1:0] step_wrap;
  logic [DEN_BITS-1:0]   last_idx;
  logic                  end_hit;
  logic [KF_BITS-1:0]    next_kf_d;
  logic [KF_BITS-1:0]    last_kf;
  logic [KF_BITS-1:0]    stop_next;
  logic                  wb_go;

  assign step_sum  = COUNT_BITS'(first_q) + COUNT_BITS'(kmod_q);
  assign step_m1   = step_sum - COUNT_BITS'(1);
  assign step_wrap = step_m1 - ce;
  assign last_idx  = DEN_BITS'(first_q) + DEN_BITS'(k_q) - DEN_BITS'(1);
  assign end_hit   = !loop_q && ((first_q == '0) || (last_idx >= DEN_BITS'(ce)));
  assign last_kf   = KF_BITS'(ce - COUNT_BITS'(1));
  assign stop_next = (ce == COUNT_BITS'(1)) ? '0 : KF_BITS'(1);

  always_comb begin
    if (step_sum == '0) begin
      next_kf_d = last_kf;
    end else if (step_m1 >= ce) begin
      next_kf_d = step_wrap[KF_BITS-1:0];
    end else begin
      next_kf_d = step_m1[KF_BITS-1:0];
    end
  end

  // result slot free, or being emptied this cycle
  assign wb_go = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= PERIOD_RESET;
      count_q     <= COUNT_RESET;
      loop_q      <= 1'b0;
      ktimer_q    <= '0;
      kcur_q      <= '0;
      knext_q     <= '0;
      kblend_q    <= '0;
      kmode_q     <= MODE_STOPPED;
      kended_q    <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_TICK;
      timer_q     <= '0;
      divn_q      <= '0;
      k_q         <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      nt_q        <= '0;
      bq_q        <= '0;
      kmod_q      <= '0;
      first_q     <= '0;
      nsh_q       <= '0;
      cnt_q       <= '0;
      stepped_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        case (cfg_index_i)
          CFG_PERIOD: period_q <= cfg_wdata_i;
          CFG_COUNT:  count_q  <= cfg_wdata_i[COUNT_BITS-1:0];
          CFG_LOOP:   loop_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      // in S_WB the commit below decides the slot
      if (out_valid_q && out_ready_i && (state_q != S_WB)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_e'(operation_i);
            timer_q <= ktimer_q + TIMER_BITS'(elapsed_time_i);
            if (op_e'(operation_i) == OP_TICK && kmode_q == MODE_PLAYING) begin
              state_q <= S_PREP;
            end else begin
              state_q <= S_WB;
            end
          end
        end

        S_PREP: begin
          cnt_q  <= '0;
          nsh_q  <= COUNT_BITS'(knext_q) + COUNT_BITS'(1);
          if (timer_q > TIMER_BITS'(pe)) begin
            stepped_q <= 1'b1;
            divn_q    <= timer_q - TIMER_BITS'(1);
            rem_q     <= '0;
            k_q       <= '0;
            kmod_q    <= '0;
            den_q     <= DEN_BITS'(pe);
            state_q   <= S_DIVK;
          end else begin
            // no frame step: blend = timer*2^16/period
            stepped_q <= 1'b0;
            k_q       <= '0;
            nt_q      <= timer_q;
            den_q     <= DEN_BITS'(pe);
            rem_q     <= DEN_BITS'(timer_q);
            bq_q      <= '0;
            first_q   <= '0;
            state_q   <= S_DIVB;
          end
        end

        S_DIVK: begin
          rem_q  <= rem_d;
          k_q    <= {k_q[TIMER_BITS-2:0], sub_res.ge};
          kmod_q <= mod_res;
          divn_q <= {divn_q[TIMER_BITS-2:0], 1'b0};
          cnt_q  <= cnt_q + STEP_BITS'(1);
          if (cnt_q == STEP_BITS'(TIMER_BITS - 1)) begin
            state_q <= S_SETB;
          end
        end

        S_SETB: begin
          nt_q    <= nt_d;
          den_q   <= den_d;
          rem_q   <= DEN_BITS'(timer_q);
          bq_q    <= '0;
          first_q <= '0;
          cnt_q   <= '0;
          state_q <= S_DIVB;
        end

        S_DIVB: begin
          rem_q <= rem_d;
          bq_q  <= {bq_q[BLEND_BITS-2:0], sub_res.ge};
          if (cnt_q < STEP_BITS'(COUNT_BITS)) begin
            first_q <= mod_res;
            nsh_q   <= {nsh_q[COUNT_BITS-2:0], 1'b0};
          end
          cnt_q <= cnt_q + STEP_BITS'(1);
          if (cnt_q == STEP_BITS'(BLEND_BITS - 1)) begin
            state_q <= S_WB;
          end
        end

        S_WB: begin
          if (wb_go) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            case (op_q)
              OP_TICK: begin
                if (kmode_q == MODE_PLAYING) begin
                  ktimer_q <= nt_q;
                  kblend_q <= bq_q;
                  if (stepped_q) begin
                    if (end_hit) begin
                      // non-looping run reached its last frame
                      kended_q <= 1'b1;
                      kmode_q  <= MODE_STOPPED;
                      kcur_q   <= last_kf;
                      knext_q  <= last_kf;
                    end else begin
                      kcur_q  <= knext_q;
                      knext_q <= next_kf_d;
                    end
                  end
                end
              end
              OP_PLAY: begin
                kended_q <= 1'b0;
                kmode_q  <= MODE_PLAYING;
              end
              OP_PAUSE: begin
                kmode_q <= MODE_PAUSED;
              end
              OP_STOP: begin
                kmode_q  <= MODE_STOPPED;
                ktimer_q <= '0;
                kblend_q <= '0;
                kcur_q   <= '0;
                knext_q  <= stop_next;
              end
              default: ;
            endcase
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign current_keyframe_o = kcur_q;
  assign next_keyframe_o    = knext_q;
  assign blend_factor_o     = kblend_q;
  assign play_mode_o        = kmode_q;
  assign animation_ended_o  = kended_q;

  // blend never exceeds one
  a_blend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kblend_q <= BLEND_ONE)
    else $error("blend factor above one");

  // held timer never exceeds a period, so it fits the time width
  a_timer_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ktimer_q[TIMER_BITS-1] == 1'b0)
    else $error("held timer out of range");

  // restoring division keeps the remainder below the divisor
  a_divk_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVK) |-> (rem_q < den_q))
    else $error("frame divider remainder out of range");

  a_divb_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVB) |-> (rem_q <= den_q))
    else $error("blend divider remainder out of range");

  // end flag only rises together with a stop
  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(kended_q) |-> (kmode_q == MODE_STOPPED))
    else $error("end flag set while not stopped");

  // a result is committed only into a free slot
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && out_valid_q && !out_ready_i) |=> (state_q == S_WB))
    else $error("result committed over a pending one");

endmodule

// ----- rtl/kpt_cmpsub.sv -----
`timescale 1ns / 1ps
// Shared compare/subtract unit used by both serial dividers.
// Depends on kpt_pkg.
module kpt_cmpsub (
  input  logic [kpt_pkg::ACC_BITS-1:0] a_i,
  input  logic [kpt_pkg::DEN_BITS-1:0] b_i,
  output kpt_pkg::sub_res_t            res_o
);
  import kpt_pkg::*;

  logic [ACC_BITS:0] wide;

  assign wide       = {1'b0, a_i} - {2'b00, b_i};
  assign res_o.ge   = ~wide[ACC_BITS];
  assign res_o.diff = wide[ACC_BITS-1:0];

endmodule

// ----- rtl/kpt_modstep.sv -----
`timescale 1ns / 1ps
// One MSB-first step of a residue modulo the keyframe count.
// Depends on kpt_pkg.
module kpt_modstep (
  input  logic [kpt_pkg::KF_BITS-1:0]    res_i,
  input  logic                           bit_i,
  input  logic [kpt_pkg::COUNT_BITS-1:0] count_i,
  output logic [kpt_pkg::KF_BITS-1:0]    res_o
);
  import kpt_pkg::*;

  logic [COUNT_BITS-1:0] dbl;
  logic [COUNT_BITS-1:0] red;

  // res_i < count, so 2*res+bit < 2*count: one subtract reduces it
  assign dbl   = {res_i, bit_i};
  assign red   = dbl - count_i;
  assign res_o = (dbl >= count_i) ? red[KF_BITS-1:0] : dbl[KF_BITS-1:0];

endmodule

// ----- test/tb_keyframe_playback_timer_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_playback_timer_top: a scoreboard class predicts
// every result transaction, plain tasks drive the operation and configuration ports.
// Depends on kpt_pkg and the RTL under rtl/.
module tb_keyframe_playback_timer_top;
  import kpt_pkg::*;

  // One result transaction as seen on the output ports.
  typedef struct packed {
    logic [KF_BITS-1:0]    cur_kf;
    logic [KF_BITS-1:0]    next_kf;
    logic [BLEND_BITS-1:0] blend;
    logic [1:0]            mode;
    logic                  ended;
  } frame_t;

  // Scoreboard: carries its own copy of the playback state and the registers,
  // predicts the frame for each accepted operation and checks results in order.
  class playback_scoreboard;
    logic [TIME_BITS-1:0]  period_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  loop_reg;
    logic [TIMER_BITS-1:0] frame_timer;
    logic [KF_BITS-1:0]    cur_kf;
    logic [KF_BITS-1:0]    next_kf;
    logic [BLEND_BITS-1:0] blend;
    mode_e                 mode;
    logic                  ended;
    frame_t                expected_frames[$];
    int unsigned           mismatches;
    int unsigned           frames_checked;
    int unsigned           end_stops;

    function new();
      period_reg     = 20'd16667;
      count_reg      = 11'd1;
      loop_reg       = 1'b0;
      frame_timer    = '0;
      cur_kf         = '0;
      next_kf        = '0;
      blend          = '0;
      mode           = MODE_STOPPED;
      ended          = 1'b0;
      mismatches     = 0;
      frames_checked = 0;
      end_stops      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_PERIOD: period_reg = data[TIME_BITS-1:0];
        CFG_COUNT:  count_reg  = data[COUNT_BITS-1:0];
        CFG_LOOP:   loop_reg   = data[0];
        default: ;
      endcase
    endfunction

    // Advance the state by one accepted operation and queue the frame it shows.
    function void note_operation(op_e op, logic [TIME_BITS-1:0] elapsed);
      longint unsigned per;
      longint unsigned cnt;
      longint unsigned t;
      longint unsigned k;
      longint unsigned first;
      frame_t f;
      per = (period_reg == 0) ? 1 : period_reg;
      if (count_reg == 0) cnt = 1;
      else if (count_reg > MAX_KEYFRAMES) cnt = MAX_KEYFRAMES;
      else cnt = count_reg;
      case (op)
        OP_TICK: begin
          if (mode == MODE_PLAYING) begin
            t = longint'(frame_timer) + longint'(elapsed);
            if (t <= per) begin
              frame_timer = TIMER_BITS'(t);
              blend = BLEND_BITS'((t << FRAC_BITS) / per);
            end else begin
              // number of whole periods stepped over in this tick
              k = (t - 1) / per;
              frame_timer = TIMER_BITS'(t - k * per);
              blend = BLEND_BITS'((t << FRAC_BITS) / ((k + 1) * per));
              cur_kf = next_kf;
              first = (longint'(next_kf) + 1) % cnt;
              if (!loop_reg && (first == 0 || first + k - 1 >= cnt)) begin
                // ran off the last frame without looping
                ended   = 1'b1;
                mode    = MODE_STOPPED;
                cur_kf  = KF_BITS'(cnt - 1);
                next_kf = KF_BITS'(cnt - 1);
                end_stops++;
              end else begin
                next_kf = KF_BITS'((first + k - 1) % cnt);
              end
            end
          end
        end
        OP_PLAY: begin
          ended = 1'b0;
          mode  = MODE_PLAYING;
        end
        OP_PAUSE: mode = MODE_PAUSED;
        default: begin
          mode        = MODE_STOPPED;
          frame_timer = '0;
          cur_kf      = '0;
          next_kf     = KF_BITS'(1 % cnt);
          blend       = '0;
        end
      endcase
      f.cur_kf  = cur_kf;
      f.next_kf = next_kf;
      f.blend   = blend;
      f.mode    = mode;
      f.ended   = ended;
      expected_frames = {expected_frames, f};
    endfunction

    function void check_frame(frame_t got);
      frame_t exp_f;
      if (expected_frames.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
        return;
      end
      exp_f = expected_frames.pop_front();
      frames_checked++;
      if (got.cur_kf !== exp_f.cur_kf) begin
        $error("current_keyframe: expected %0d, got %0d", exp_f.cur_kf, got.cur_kf);
        mismatches++;
      end
      if (got.next_kf !== exp_f.next_kf) begin
        $error("next_keyframe: expected %0d, got %0d", exp_f.next_kf, got.next_kf);
        mismatches++;
      end
      if (got.blend !== exp_f.blend) begin
        $error("blend_factor: expected %0d, got %0d", exp_f.blend, got.blend);
        mismatches++;
      end
      if (got.mode !== exp_f.mode) begin
        $error("play_mode: expected %0d, got %0d", exp_f.mode, got.mode);
        mismatches++;
      end
      if (got.ended !== exp_f.ended) begin
        $error("animation_ended: expected %0d, got %0d", exp_f.ended, got.ended);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_wr_en_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i    = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               operation_i    = '0;
  logic [TIME_BITS-1:0]     elapsed_time_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [KF_BITS-1:0]       current_keyframe_o;
  logic [KF_BITS-1:0]       next_keyframe_o;
  logic [BLEND_BITS-1:0]    blend_factor_o;
  logic [1:0]               play_mode_o;
  logic                     animation_ended_o;

  playback_scoreboard sb;

  // idle limits for each side, changed per phase; 0 gives back-to-back traffic
  int unsigned sender_gap_max      = 0;
  int unsigned receiver_stall_max  = 0;
  // one-shot long hold-off of the result side, consumed by the sink process
  int unsigned hold_results_cycles = 0;
  int unsigned ops_sent            = 0;
  int unsigned settings_written    = 0;

  keyframe_playback_timer_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .elapsed_time_i     (elapsed_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .current_keyframe_o (current_keyframe_o),
    .next_keyframe_o    (next_keyframe_o),
    .blend_factor_o     (blend_factor_o),
    .play_mode_o        (play_mode_o),
    .animation_ended_o  (animation_ended_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one operation after a random gap and hold it until the block takes it.
  // Valid stays high across back-to-back transactions (gap of zero).
  task automatic send_op(input op_e op, input logic [TIME_BITS-1:0] elapsed);
    int unsigned gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    elapsed_time_i <= elapsed;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operation(op, elapsed);
    ops_sent++;
  endtask

  // Stop offering and wait until every predicted frame has come out.
  task automatic drain_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
  endtask

  // Write all three registers, one per clock; only called with the block idle.
  task automatic write_config(input logic [TIME_BITS-1:0] period,
                              input logic [COUNT_BITS-1:0] count, input logic loop_on);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= CFG_PERIOD;
    cfg_wdata_i <= CFG_DATA_BITS'(period);
    @(posedge clk_i);
    sb.write_reg(CFG_PERIOD, CFG_DATA_BITS'(period));
    cfg_index_i <= CFG_COUNT;
    cfg_wdata_i <= CFG_DATA_BITS'(count);
    @(posedge clk_i);
    sb.write_reg(CFG_COUNT, CFG_DATA_BITS'(count));
    cfg_index_i <= CFG_LOOP;
    cfg_wdata_i <= CFG_DATA_BITS'(loop_on);
    @(posedge clk_i);
    sb.write_reg(CFG_LOOP, CFG_DATA_BITS'(loop_on));
    cfg_wr_en_i <= 1'b0;
    settings_written++;
  endtask

  // Result side: random stall before each transaction, plus the long hold-off
  // when one is requested, so the block backs up and drops in_ready_o.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_results_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_results_cycles) @(posedge clk_i);
        hold_results_cycles = 0;
      end
      stall = $urandom_range(0, receiver_stall_max);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Sample outputs at the edge where the transaction completes.
  always @(posedge clk_i) begin : result_monitor
    frame_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{current_keyframe_o, next_keyframe_o, blend_factor_o, play_mode_o,
              animation_ended_o};
      sb.check_frame(got);
    end
  end

  initial begin : stimulus
    int                    phase;
    int                    n;
    logic [TIME_BITS-1:0]  period_pick;
    logic [COUNT_BITS-1:0] count_pick;
    longint unsigned       per;
    longint unsigned       upper;
    logic [TIME_BITS-1:0]  elapsed;
    op_e                   op_pick;
    int unsigned           r;

    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: reset settings (one frame, no loop, 16667 us period)
    send_op(OP_TICK, 20'hFFFFF);         // tick while stopped shows held state
    send_op(OP_PLAY, 20'h0);
    send_op(OP_TICK, 20'h0);
    send_op(OP_TICK, 20'd16667);         // exactly one period: no step, blend of one
    send_op(OP_TICK, 20'd1);             // step on a single frame: end reached
    send_op(OP_PAUSE, 20'hFFFFF);
    send_op(OP_TICK, 20'd500);           // paused tick changes nothing
    send_op(OP_STOP, 20'h0);

    // zero period and zero count both act as one, looping on
    drain_results();
    write_config(20'h0, 11'h0, 1'b1);
    send_op(OP_PLAY, 20'h0);
    send_op(OP_TICK, 20'hFFFFF);
    send_op(OP_TICK, 20'd1);

    // longest period, count above the limit saturates, no loop
    drain_results();
    write_config(20'hFFFFF, 11'h7FF, 1'b0);
    send_op(OP_STOP, 20'hFFFFF);
    send_op(OP_PLAY, 20'h0);
    send_op(OP_TICK, 20'hFFFFF);
    send_op(OP_TICK, 20'hFFFFF);
    send_op(OP_TICK, 20'd1);

    // short frames, then the count is lowered so the held next keyframe falls outside it
    drain_results();
    write_config(20'd3, 11'd5, 1'b1);
    send_op(OP_PLAY, 20'h0);
    send_op(OP_TICK, 20'd12);
    send_op(OP_TICK, 20'd3);
    drain_results();
    write_config(20'd3, 11'd3, 1'b0);
    send_op(OP_TICK, 20'd4);

    // --- random phases: fresh settings each time, mostly playing ticks
    for (phase = 0; phase < 22; phase++) begin
      drain_results();
      case ($urandom_range(0, 7))
        0: period_pick = 20'h0;
        1: period_pick = 20'd1;
        2: period_pick = 20'hFFFFF;
        3: period_pick = 20'd16667;
        4, 5: period_pick = TIME_BITS'($urandom_range(2, 64));
        6: period_pick = TIME_BITS'($urandom_range(65, 5000));
        default: period_pick = TIME_BITS'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: count_pick = 11'd0;
        1: count_pick = 11'd1;
        2: count_pick = 11'd2;
        3: count_pick = COUNT_BITS'($urandom_range(3, 8));
        4: count_pick = COUNT_BITS'($urandom_range(9, 40));
        5: count_pick = 11'd1024;
        6: count_pick = COUNT_BITS'($urandom_range(1025, 2047));
        default: count_pick = 11'd1023;
      endcase
      write_config(period_pick, count_pick, 1'($urandom_range(0, 1)));
      sender_gap_max     = ($urandom_range(0, 3) == 0) ? 0 : 18;
      receiver_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
      if (phase == 4) begin
        // back up the block: result side holds off while operations keep coming
        hold_results_cycles = 300;
        sender_gap_max      = 0;
      end
      per = (sb.period_reg == 0) ? 1 : sb.period_reg;
      upper = 3 * per;
      if (upper > 20'hFFFFF) upper = 20'hFFFFF;
      for (n = 0; n < 25; n++) begin
        if (phase == 9 && n == 12) drain_results();   // sender pause until all results in
        r = $urandom_range(0, 99);
        if (sb.mode != MODE_PLAYING && r < 60) op_pick = OP_PLAY;
        else if (r < 72) op_pick = OP_TICK;
        else if (r < 82) op_pick = OP_PLAY;
        else if (r < 90) op_pick = OP_PAUSE;
        else op_pick = OP_STOP;
        case ($urandom_range(0, 9))
          0: elapsed = 20'h0;
          1: elapsed = 20'hFFFFF;
          2, 3: elapsed = TIME_BITS'($urandom);
          default: elapsed = TIME_BITS'($urandom_range(0, int'(upper)));
        endcase
        send_op(op_pick, elapsed);
      end
    end

    drain_results();
    // let anything stray show up before closing
    repeat (60) @(posedge clk_i);
    $display("Covered %0d operations, %0d results checked, %0d register settings.",
             ops_sent, sb.frames_checked, settings_written);
    $display("Non-looping animations ran to their end %0d times.", sb.end_stops);
    if (sb.mismatches == 0) begin
      $display("tb_keyframe_playback_timer_top: clean");
    end else begin
      $display("tb_keyframe_playback_timer_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("Timed out waiting for the block.");
    $display("tb_keyframe_playback_timer_top: errors");
    $finish;
  end

endmodule
